// ===== hdl/sprle_pkg.sv =====
package sprle_pkg;

  localparam int MAX_WIDTH_DEF  = 720;
  localparam int MAX_HEIGHT_DEF = 576;

  localparam logic [9:0] LINE_WIDTH_RST   = 10'd720;
  localparam logic [9:0] AREA_HEIGHT_RST  = 10'd576;
  localparam logic       FIELD_PARITY_RST = 1'b0;

  localparam logic [15:0] CODE_LIM1 = 16'h0004;
  localparam logic [15:0] CODE_LIM2 = 16'h0010;
  localparam logic [15:0] CODE_LIM3 = 16'h0040;
  localparam logic [3:0]  NIB_LIM   = 4'h4;

  typedef enum logic [1:0] {
    CFG_LINE_WIDTH,
    CFG_AREA_HEIGHT,
    CFG_FIELD_PARITY
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] rle_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] pixel_color;
    logic [9:0] run_length;
    logic [9:0] run_start;
    logic [9:0] line_number;
    logic       line_end;
    logic       field_done;
    logic       last_of_item;
  } out_t;

  typedef struct packed {
    logic [9:0] width;
    logic [9:0] height;
    logic       parity;
    logic       restart;
  } cfg_ctl_t;

endpackage

// ===== hdl/subpicture_rle_field_decoder_unit.sv =====
// a byte is registered in the holding stage, where its high nibble and then its low
// nibble are decoded; each run is then registered in the output register
// throughput: one nibble decoded per cycle while the output register is not stalled
// sustained rate is set by the single nibble decode step feeding one run per cycle
// synchronous active-low reset restores register defaults and restarts the field
module subpicture_rle_field_decoder_unit #(
  parameter int MAX_WIDTH  = sprle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sprle_pkg::MAX_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sprle_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sprle_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [9:0]      cfg_data
);

  sprle_pkg::cfg_ctl_t ctl;
  logic                res_valid;
  logic                res_ready;
  sprle_pkg::out_t     res_data;

  assign cfg_ready = 1'b1;

  sprle_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl)
  );

  sprle_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  sprle_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sprle_cfg.sv =====
module sprle_cfg #(
  parameter int MAX_WIDTH  = sprle_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sprle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  output sprle_pkg::cfg_ctl_t ctl
);

  logic [9:0] width_r, width_nxt;
  logic [9:0] height_r, height_nxt;
  logic       parity_r, parity_nxt;
  logic       restart_r, restart_nxt;

  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    parity_nxt  = parity_r;
    restart_nxt = 1'b0;
    if (cfg_valid) begin
      case (sprle_pkg::cfg_idx_t'(cfg_index))
        sprle_pkg::CFG_LINE_WIDTH: begin
          width_nxt   = cfg_data;
          restart_nxt = 1'b1;
        end
        sprle_pkg::CFG_AREA_HEIGHT: begin
          height_nxt  = cfg_data;
          restart_nxt = 1'b1;
        end
        sprle_pkg::CFG_FIELD_PARITY: begin
          parity_nxt  = cfg_data[0];
          restart_nxt = 1'b1;
        end
        default: begin
          restart_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= sprle_pkg::LINE_WIDTH_RST;
      height_r  <= sprle_pkg::AREA_HEIGHT_RST;
      parity_r  <= sprle_pkg::FIELD_PARITY_RST;
      restart_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      parity_r  <= parity_nxt;
      restart_r <= restart_nxt;
    end
  end

  // effective width and height after clamping
  always_comb begin
    if (width_r == 10'd0) begin
      ctl.width = 10'd1;
    end else if (int'(width_r) > MAX_WIDTH) begin
      ctl.width = 10'(MAX_WIDTH);
    end else begin
      ctl.width = width_r;
    end
    if (int'(height_r) > MAX_HEIGHT) begin
      ctl.height = 10'(MAX_HEIGHT);
    end else begin
      ctl.height = height_r;
    end
    ctl.parity  = parity_r;
    ctl.restart = restart_r;
  end

endmodule

// ===== hdl/sprle_dec.sv =====
module sprle_dec (
  input  logic                clk,
  input  logic                rst_n,
  input  sprle_pkg::cfg_ctl_t ctl,
  input  logic                in_valid,
  output logic                in_stall,
  input  sprle_pkg::in_t      in_data,
  input  logic                res_ready,
  output logic                res_valid,
  output sprle_pkg::out_t     res_data
);

  // input holding stage
  logic           hold_v_r, hold_v_nxt;
  sprle_pkg::in_t hold_r, hold_nxt;
  logic           ph_r, ph_nxt;

  // decode state
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [9:0]  x_r, x_nxt;
  logic [10:0] line_r, line_nxt;
  logic        fin_r, fin_nxt;

  logic [3:0]  nib;
  logic [15:0] acc_new;
  logic [2:0]  held_new;
  logic        done_code;
  logic [13:0] count;
  logic [9:0]  rem;
  logic [9:0]  run_len;
  logic [10:0] x_sum;
  logic [10:0] line_step;
  logic        eol;
  logic        fdone;
  logic        emit;
  logic        adv;
  logic        byte_done;
  logic        in_acc;
  logic        restart_fin;

  assign nib      = ph_r ? hold_r.rle_byte[3:0] : hold_r.rle_byte[7:4];
  assign acc_new  = {acc_r[11:0], nib};
  assign held_new = {1'b0, held_r} + 3'd1;

  assign done_code = (held_new == 3'd1 && acc_new >= sprle_pkg::CODE_LIM1) ||
                     (held_new == 3'd2 && acc_new >= sprle_pkg::CODE_LIM2) ||
                     (held_new == 3'd3 && acc_new >= sprle_pkg::CODE_LIM3) ||
                     (held_new == 3'd4);

  assign count = acc_new[15:2];
  assign rem   = (x_r < ctl.width) ? (ctl.width - x_r) : 10'd1;

  always_comb begin
    if (count == 14'd0 || count > {4'd0, rem}) begin
      run_len = rem;
    end else begin
      run_len = count[9:0];
    end
  end

  assign x_sum     = {1'b0, x_r} + {1'b0, run_len};
  assign eol       = x_sum >= {1'b0, ctl.width};
  assign line_step = line_r + 11'd2;
  assign fdone     = eol && (line_step >= {1'b0, ctl.height});

  assign emit      = hold_v_r && !fin_r && done_code;
  assign adv       = hold_v_r && res_ready;
  assign byte_done = ph_r || fin_r || (emit && eol);
  assign in_stall  = hold_v_r && !(adv && byte_done);
  assign in_acc    = in_valid && !in_stall;

  assign restart_fin = {10'd0, ctl.parity} >= {1'b0, ctl.height};

  assign res_valid = adv && emit;

  always_comb begin
    res_data.pixel_color  = acc_new[1:0];
    res_data.run_length   = run_len;
    res_data.run_start    = x_r;
    res_data.line_number  = line_r[9:0];
    res_data.line_end     = eol;
    res_data.field_done   = fdone;
    // the low nibble only yields a run on its own when it is a full code
    res_data.last_of_item = ph_r || eol || (hold_r.rle_byte[3:0] < sprle_pkg::NIB_LIM);
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    ph_nxt     = ph_r;
    acc_nxt    = acc_r;
    held_nxt   = held_r;
    x_nxt      = x_r;
    line_nxt   = line_r;
    fin_nxt    = fin_r;
    if (adv) begin
      if (!fin_r) begin
        if (done_code) begin
          acc_nxt  = 16'd0;
          held_nxt = 2'd0;
          if (eol) begin
            x_nxt    = 10'd0;
            line_nxt = line_step;
            fin_nxt  = fdone;
          end else begin
            x_nxt = x_sum[9:0];
          end
        end else begin
          acc_nxt  = acc_new;
          held_nxt = held_new[1:0];
        end
      end
      if (byte_done) begin
        ph_nxt     = 1'b0;
        hold_v_nxt = 1'b0;
        if (hold_r.final_byte) begin
          acc_nxt  = 16'd0;
          held_nxt = 2'd0;
          x_nxt    = 10'd0;
          line_nxt = {10'd0, ctl.parity};
          fin_nxt  = restart_fin;
        end
      end else begin
        ph_nxt = 1'b1;
      end
    end
    if (ctl.restart) begin
      acc_nxt  = 16'd0;
      held_nxt = 2'd0;
      x_nxt    = 10'd0;
      line_nxt = {10'd0, ctl.parity};
      fin_nxt  = restart_fin;
    end
    if (in_acc) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = in_data;
      ph_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      ph_r     <= 1'b0;
      acc_r    <= 16'd0;
      held_r   <= 2'd0;
      x_r      <= 10'd0;
      line_r   <= {10'd0, sprle_pkg::FIELD_PARITY_RST};
      fin_r    <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      ph_r     <= ph_nxt;
      acc_r    <= acc_nxt;
      held_r   <= held_nxt;
      x_r      <= x_nxt;
      line_r   <= line_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

// ===== hdl/sprle_out.sv =====
module sprle_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  sprle_pkg::out_t res_data,
  output logic            res_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output sprle_pkg::out_t out_data
);

  logic            valid_r, valid_nxt;
  sprle_pkg::out_t data_r, data_nxt;

  assign res_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (res_ready) begin
      valid_nxt = res_valid;
      if (res_valid) begin
        data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== tb/tb_subpicture_rle_field_decoder_unit.sv =====
module tb_subpicture_rle_field_decoder_unit;

  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         RANDOM_BYTES  = 800;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  sprle_pkg::in_t      in_data   = '0;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [9:0]          cfg_data  = '0;
  logic                in_stall;
  logic                out_valid;
  sprle_pkg::out_t     out_data;
  logic                cfg_ready;

  // decoder shadow: registers and field state
  logic [9:0]  width_reg;
  logic [9:0]  height_reg;
  logic        parity_reg;
  logic [15:0] code_bits;
  int          nib_count;
  int          pos_x;
  int          line_no;
  bit          field_full;

  sprle_pkg::out_t pending_runs[$];
  sprle_pkg::out_t want_run;
  int   err_count  = 0;
  int   sent_bytes = 0;
  bit   idle_en    = 1'b0;
  bit   stall_en   = 1'b0;
  int   stall_left = 0;

  always #4 clk = ~clk;

  subpicture_rle_field_decoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > sprle_pkg::MAX_WIDTH_DEF) return sprle_pkg::MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg > sprle_pkg::MAX_HEIGHT_DEF) return sprle_pkg::MAX_HEIGHT_DEF;
    return int'(height_reg);
  endfunction

  function automatic void restart_field();
    code_bits  = '0;
    nib_count  = 0;
    pos_x      = 0;
    line_no    = int'(parity_reg);
    field_full = (line_no >= eff_height());
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [9:0] val);
    case (idx)
      sprle_pkg::CFG_LINE_WIDTH: begin
        width_reg = val;
      end
      sprle_pkg::CFG_AREA_HEIGHT: begin
        height_reg = val;
      end
      sprle_pkg::CFG_FIELD_PARITY: begin
        parity_reg = val[0];
      end
      default: begin
        return;
      end
    endcase
    restart_field();
  endfunction

  // split one byte into nibbles, build codes and queue the runs they give
  function automatic void decode_byte(input sprle_pkg::in_t beat);
    int              w;
    int              h;
    int              cnt;
    int              rem;
    int              held;
    int              n;
    logic [3:0]      nib;
    bit              done_code;
    sprle_pkg::out_t runs[2];
    w = eff_width();
    h = eff_height();
    n = 0;
    sent_bytes++;
    for (int k = 0; k < 2; k++) begin
      if (field_full) break;
      nib = (k == 0) ? beat.rle_byte[7:4] : beat.rle_byte[3:0];
      code_bits = {code_bits[11:0], nib};
      held = nib_count + 1;
      done_code = (held == 1 && code_bits >= sprle_pkg::CODE_LIM1) ||
                  (held == 2 && code_bits >= sprle_pkg::CODE_LIM2) ||
                  (held == 3 && code_bits >= sprle_pkg::CODE_LIM3) || held >= 4;
      if (!done_code) begin
        nib_count = held;
        continue;
      end
      cnt = int'(code_bits >> 2);
      runs[n] = '0;
      runs[n].pixel_color = code_bits[1:0];
      code_bits = '0;
      nib_count = 0;
      rem = (pos_x < w) ? w - pos_x : 1;
      if (cnt == 0 || cnt > rem) cnt = rem;
      runs[n].run_length  = 10'(cnt);
      runs[n].run_start   = 10'(pos_x);
      runs[n].line_number = 10'(line_no);
      pos_x += cnt;
      if (pos_x >= w) begin
        runs[n].line_end = 1'b1;
        pos_x = 0;
        line_no += 2;
        if (line_no >= h) begin
          runs[n].field_done = 1'b1;
          field_full = 1'b1;
        end
      end
      n++;
      if (runs[n - 1].line_end) break;
    end
    if (n > 0) runs[n - 1].last_of_item = 1'b1;
    for (int i = 0; i < n; i++) pending_runs.push_back(runs[i]);
    if (beat.final_byte) restart_field();
  endfunction

  function automatic int burst_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (!idle_en || $urandom_range(0, 1) == 0) return 0;
    return burst_len();
  endfunction

  // bias nibbles low so that longer codes show up often
  function automatic logic [3:0] pick_nib();
    case ($urandom_range(0, 3))
      0: begin
        return 4'h0;
      end
      1: begin
        return 4'($urandom_range(1, 3));
      end
      default: begin
        return 4'($urandom_range(0, 15));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_data.rle_byte    <= b;
    in_data.final_byte  <= fin;
    do @(posedge clk); while (in_stall);
    decode_byte(in_data);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_en && $urandom_range(0, 99) >= 70) begin
      stall_left <= burst_len() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("run with none expected");
      end else begin
        want_run = pending_runs.pop_front();
        if (out_data.pixel_color !== want_run.pixel_color)
          report_mismatch($sformatf("pixel_color got %0d want %0d",
                                    out_data.pixel_color, want_run.pixel_color));
        if (out_data.run_length !== want_run.run_length)
          report_mismatch($sformatf("run_length got %0d want %0d",
                                    out_data.run_length, want_run.run_length));
        if (out_data.run_start !== want_run.run_start)
          report_mismatch($sformatf("run_start got %0d want %0d",
                                    out_data.run_start, want_run.run_start));
        if (out_data.line_number !== want_run.line_number)
          report_mismatch($sformatf("line_number got %0d want %0d",
                                    out_data.line_number, want_run.line_number));
        if (out_data.line_end !== want_run.line_end)
          report_mismatch($sformatf("line_end got %0b want %0b",
                                    out_data.line_end, want_run.line_end));
        if (out_data.field_done !== want_run.field_done)
          report_mismatch($sformatf("field_done got %0b want %0b",
                                    out_data.field_done, want_run.field_done));
        if (out_data.last_of_item !== want_run.last_of_item)
          report_mismatch($sformatf("last_of_item got %0b want %0b",
                                    out_data.last_of_item, want_run.last_of_item));
      end
    end
  end

  // default registers: every code length, fill to line end, cut-off code
  task automatic test_code_forms();
    logic [7:0] seq[13] = '{8'h00, 8'h00, 8'hFF, 8'h41, 8'h23, 8'h0F, 8'h01,
                            8'h2A, 8'h0A, 8'hBC, 8'h03, 8'hFF, 8'h01};
    foreach (seq[i]) send_byte(seq[i], i == 12);
  endtask

  // zero width acts as one pixel; overlong run clipped, rest of byte skipped
  task automatic test_narrow_lines();
    write_reg(sprle_pkg::CFG_LINE_WIDTH, 10'd0);
    write_reg(sprle_pkg::CFG_AREA_HEIGHT, 10'd4);
    write_reg(sprle_pkg::CFG_FIELD_PARITY, 10'd0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // oversized width and height are clamped
  task automatic test_wide_limits();
    write_reg(sprle_pkg::CFG_LINE_WIDTH, 10'h3FF);
    write_reg(sprle_pkg::CFG_AREA_HEIGHT, 10'h3FF);
    write_reg(sprle_pkg::CFG_FIELD_PARITY, 10'd1);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // empty field from the start, and the unused register index
  task automatic test_dead_field();
    write_reg(sprle_pkg::CFG_AREA_HEIGHT, 10'd0);
    send_byte(8'hFF, 1'b0);
    write_reg(sprle_pkg::CFG_AREA_HEIGHT, 10'd1);
    send_byte(8'hFF, 1'b1);
    write_reg(CFG_UNUSED, 10'h155);
  endtask

  task automatic test_random_fields();
    int   start;
    int   r;
    int   nbytes;
    logic fin;
    start = sent_bytes;
    while (sent_bytes - start < RANDOM_BYTES) begin
      stall_en = ($urandom_range(0, 3) != 0);
      idle_en  = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 10) write_reg(sprle_pkg::CFG_LINE_WIDTH, 10'($urandom_range(0, 1023)));
      else if (r < 20) write_reg(sprle_pkg::CFG_LINE_WIDTH, 10'd720);
      else write_reg(sprle_pkg::CFG_LINE_WIDTH, 10'($urandom_range(1, 24)));
      r = $urandom_range(0, 99);
      if (r < 10) write_reg(sprle_pkg::CFG_AREA_HEIGHT, 10'($urandom_range(0, 1023)));
      else write_reg(sprle_pkg::CFG_AREA_HEIGHT, 10'($urandom_range(1, 16)));
      write_reg(sprle_pkg::CFG_FIELD_PARITY, 10'($urandom_range(0, 1023)));
      if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, 10'($urandom_range(0, 1023)));
      nbytes = $urandom_range(20, 60);
      repeat (nbytes) begin
        fin = field_full ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 29) == 0);
        send_byte({pick_nib(), pick_nib()}, fin);
        if ($urandom_range(0, 49) == 0) drain();
      end
    end
  endtask

  initial begin
    width_reg  = sprle_pkg::LINE_WIDTH_RST;
    height_reg = sprle_pkg::AREA_HEIGHT_RST;
    parity_reg = sprle_pkg::FIELD_PARITY_RST;
    restart_field();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_code_forms();
    test_narrow_lines();
    test_wide_limits();
    test_dead_field();
    test_random_fields();
    drain();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sprle_pkg.sv
hdl/sprle_cfg.sv
hdl/sprle_dec.sv
hdl/sprle_out.sv
hdl/subpicture_rle_field_decoder_unit.sv
tb/tb_subpicture_rle_field_decoder_unit.sv
